FILE: sv/mrq_pkg.sv
package mrq_pkg;

    localparam int ID_W      = 10;
    localparam int CMD_W     = 2;
    localparam int PRIO_W    = 3;
    localparam int CFG_W     = 5;
    localparam int LVL_MAX   = 8;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd2;

    localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 5'd16;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ID_W-1:0]   task_id;
        logic [PRIO_W-1:0] priority_req;
    } t_in;

    typedef struct packed {
        logic            ok;
        logic            next_valid;
        logic [ID_W-1:0] next_id;
    } t_out;

    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] level;
    } t_slot;

    typedef struct packed {
        logic [LVL_MAX-1:0] seen_m;
        logic [LVL_MAX-1:0] seen_v;
        logic               del;
        logic               lvalid;
    } t_link;

    typedef struct packed {
        logic              ins;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] level;
    } t_cell_ctl;

    typedef struct packed {
        logic              rem;
        logic [PRIO_W-1:0] rlev;
        logic [PRIO_W-1:0] hlev;
    } t_cell_sel;

endpackage

FILE: sv/mrq_cell.sv
module mrq_cell
    import mrq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_cell_sel i_sel,
    input  t_link     i_link,
    input  t_slot     i_right,
    output t_link     o_link,
    output t_slot     o_slot,
    output logic      o_head
);

    logic              r_valid;
    logic [ID_W-1:0]   r_id;
    logic [PRIO_W-1:0] r_level;
    logic              n_valid;
    logic [ID_W-1:0]   n_id;
    logic [PRIO_W-1:0] n_level;
    logic              match;
    logic              target;
    logic [LVL_MAX-1:0] lvl_hot;

    assign lvl_hot = LVL_MAX'(1) << r_level;
    assign match   = r_valid && (r_id == i_ctl.id);
    assign target  = match && (r_level == i_sel.rlev) && !i_link.seen_m[i_sel.rlev];

    assign o_link.seen_m = i_link.seen_m | (match ? lvl_hot : '0);
    assign o_link.seen_v = i_link.seen_v | (r_valid ? lvl_hot : '0);
    assign o_link.del    = i_link.del | target;
    assign o_link.lvalid = r_valid;

    assign o_head = r_valid && (r_level == i_sel.hlev) && !i_link.seen_v[i_sel.hlev];

    assign o_slot.valid = r_valid;
    assign o_slot.id    = r_id;
    assign o_slot.level = r_level;

    always_comb begin
        n_valid = r_valid;
        n_id    = r_id;
        n_level = r_level;
        if (i_sel.rem && (i_link.del || target)) begin
            n_valid = i_right.valid;
            n_id    = i_right.id;
            n_level = i_right.level;
        end else if (i_ctl.ins && !r_valid && i_link.lvalid) begin
            n_valid = 1'b1;
            n_id    = i_ctl.id;
            n_level = i_ctl.level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_id    <= n_id;
        r_level <= n_level;
    end

endmodule

FILE: sv/multilevel_ready_queue_top.sv
// Ready queue of task ids in priority levels, level 0 first and FIFO within a level. Each
// beat goes through capture, one update of the cell row (insert at the first free cell, or
// removal of the first match at the lowest level that holds the id, with the cells behind
// it moving up one place), then the head search over the updated row. A new beat is taken
// the cycle after the result is loaded into the output register; the head stage waits while
// that register still holds an untaken beat. The limit register can be written at any time
// the queue is idle and is always ready out of reset.
module multilevel_ready_queue_top
    import mrq_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int LEVELS   = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in              i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out             o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_HEAD} t_state;

    t_state            r_state;
    logic [CMD_W-1:0]  r_cmd;
    logic [ID_W-1:0]   r_id;
    logic [PRIO_W-1:0] r_prio;
    logic              r_ok;
    logic [CNT_W-1:0]  r_count;
    logic [CFG_W-1:0]  r_max;
    logic              r_out_valid;
    t_out              r_out;

    t_link     link [CAPACITY+1];
    t_slot     slot [CAPACITY];
    logic      head [CAPACITY];
    t_cell_ctl ctl;
    t_cell_sel sel;

    logic              prio_ok;
    logic              full;
    logic              found;
    logic              any_v;
    logic              is_peek;
    logic              ins_do;
    logic [PRIO_W-1:0] rlev;
    logic [PRIO_W-1:0] hlev;
    logic [ID_W-1:0]   head_id;

    assign prio_ok = (PRIO_W + 1)'(r_prio) < (PRIO_W + 1)'(LEVELS);
    assign full    = (CMP_W'(r_count) >= CMP_W'(r_max)) || (r_count >= CNT_W'(CAPACITY));
    assign found   = |link[CAPACITY].seen_m;
    assign any_v   = |link[CAPACITY].seen_v;
    assign is_peek = (r_cmd != CMD_INSERT) && (r_cmd != CMD_REMOVE);
    assign ins_do  = (r_state == S_EXEC) && (r_cmd == CMD_INSERT) && prio_ok && !full;

    always_comb begin
        rlev = '0;
        hlev = '0;
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (link[CAPACITY].seen_m[l]) begin
                rlev = PRIO_W'(l);
            end
            if (link[CAPACITY].seen_v[l]) begin
                hlev = PRIO_W'(l);
            end
        end
    end

    assign ctl.ins   = ins_do;
    assign ctl.id    = r_id;
    assign ctl.level = r_prio;
    assign sel.rem   = (r_state == S_EXEC) && (r_cmd == CMD_REMOVE) && found;
    assign sel.rlev  = rlev;
    assign sel.hlev  = hlev;

    assign link[0].seen_m = '0;
    assign link[0].seen_v = '0;
    assign link[0].del    = 1'b0;
    assign link[0].lvalid = 1'b1;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_slot right;
        if (g == CAPACITY - 1) begin : g_last
            assign right = '0;
        end else begin : g_mid
            assign right = slot[g+1];
        end
        mrq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_sel   (sel),
            .i_link  (link[g]),
            .i_right (right),
            .o_link  (link[g+1]),
            .o_slot  (slot[g]),
            .o_head  (head[g])
        );
    end

    always_comb begin
        head_id = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            head_id = head_id | ({ID_W{head[i]}} & slot[i].id);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_max       <= MAX_ENTRIES_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_max <= i_cfg_data;
            end
            if (o_out_valid && i_out_ready && (r_state != S_HEAD)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd   <= i_in_data.cmd;
                        r_id    <= i_in_data.task_id;
                        r_prio  <= i_in_data.priority_req;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (r_cmd == CMD_INSERT) begin
                        r_ok <= !prio_ok || !full;
                        if (ins_do) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                    end else begin
                        r_ok <= found;
                        if (sel.rem) begin
                            r_count <= r_count - CNT_W'(1);
                        end
                    end
                    r_state <= S_HEAD;
                end
                S_HEAD: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out.ok         <= is_peek ? any_v : r_ok;
                        r_out.next_valid <= any_v;
                        r_out.next_id    <= head_id;
                        r_out_valid      <= 1'b1;
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE) && i_rst_n;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = i_rst_n;

endmodule

FILE: sv/mrq_checker.sv
module mrq_checker
    import mrq_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_ready,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input t_out             o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("Result beat dropped before it was taken.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Result beat present after reset.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("Input beat taken while the previous one was still in progress.");

    a_empty_id_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.next_valid |-> o_out_data.next_id == '0)
        else $error("Head id not zero on an empty queue.");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("Result beat appeared without an input beat in progress.");

endmodule

bind multilevel_ready_queue_top mrq_checker u_mrq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

FILE: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mrq_pkg::*;

    localparam int DEPTH      = 16;
    localparam int NUM_LEVELS = 4;
    localparam int STALL_MAX  = 3000;
    localparam int HOLD_LEN   = 400;
    localparam int POOL_N     = 8;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic             i_clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    t_in              in_data = '0;
    logic             out_ready = 1'b0;
    logic             cfg_valid = 1'b0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             in_ready;
    logic             out_valid;
    logic             cfg_ready;
    t_out             out_data;

    multilevel_ready_queue_top #(
        .CAPACITY(DEPTH),
        .LEVELS  (NUM_LEVELS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    t_in  pending_beats[$];
    t_out expected_results[$];
    int   n_pushed = 0;
    int   n_accepted = 0;
    int   n_results = 0;
    int   n_err = 0;
    int   idle_pct = 32;
    int   hold_seq = 0;

    int   n_stored = 0;
    int   n_refused = 0;
    int   n_ignored = 0;
    int   n_found = 0;
    int   n_missed = 0;
    int   n_peeks = 0;
    int   n_limits = 0;
    int   peak_fill = 0;

    logic [ID_W-1:0] id_pool[POOL_N];

    // Shadow of the queue contents, kept in arrival order as the block keeps them.
    logic [ID_W-1:0]  q_id[DEPTH];
    logic [1:0]       q_lvl[DEPTH];
    bit               q_used[DEPTH];
    int               q_count;
    logic [CFG_W-1:0] q_limit;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_out apply_beat(t_in b);
        t_out r;
        int   hit;
        int   head;
        r    = '0;
        hit  = -1;
        head = -1;
        case (b.cmd)
            CMD_INSERT: begin
                if (b.priority_req >= NUM_LEVELS) begin
                    r.ok = 1'b1;
                end else if (q_count < q_limit && q_count < DEPTH) begin
                    q_id[q_count]   = b.task_id;
                    q_lvl[q_count]  = b.priority_req[1:0];
                    q_used[q_count] = 1'b1;
                    q_count++;
                    r.ok = 1'b1;
                end
            end
            CMD_REMOVE: begin
                for (int l = 0; l < NUM_LEVELS && hit < 0; l++)
                    for (int i = 0; i < q_count && hit < 0; i++)
                        if (q_used[i] && q_lvl[i] == l && q_id[i] == b.task_id)
                            hit = i;
                if (hit >= 0) begin
                    for (int j = hit; j + 1 < q_count; j++) begin
                        q_id[j]   = q_id[j+1];
                        q_lvl[j]  = q_lvl[j+1];
                        q_used[j] = q_used[j+1];
                    end
                    q_count--;
                    q_used[q_count] = 1'b0;
                    r.ok = 1'b1;
                end
            end
            default: ;
        endcase
        for (int l = 0; l < NUM_LEVELS && head < 0; l++)
            for (int i = 0; i < q_count && head < 0; i++)
                if (q_used[i] && q_lvl[i] == l)
                    head = i;
        if (b.cmd != CMD_INSERT && b.cmd != CMD_REMOVE)
            r.ok = (head >= 0);
        if (head >= 0) begin
            r.next_valid = 1'b1;
            r.next_id    = q_id[head];
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_ready) begin
            if (pending_beats.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                in_data  <= pending_beats.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : rx_side
        int hold_left;
        int hold_seen;
        if (!rst_n) begin
            out_ready <= 1'b0;
            hold_left = 0;
            hold_seen = 0;
        end else begin
            if (hold_seen != hold_seq) begin
                hold_seen = hold_seq;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_out want;
        if (!rst_n) begin
            q_count = 0;
            q_limit = MAX_ENTRIES_RST;
            for (int i = 0; i < DEPTH; i++) q_used[i] = 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                n_results++;
                if (expected_results.size() == 0) begin
                    n_err++;
                    $error("result beat with nothing expected: ok %0d next_valid %0d id %0d",
                           out_data.ok, out_data.next_valid, out_data.next_id);
                end else begin
                    want = expected_results.pop_front();
                    if (out_data.ok !== want.ok) begin
                        n_err++;
                        $error("ok: expected %0d, got %0d", want.ok, out_data.ok);
                    end
                    if (out_data.next_valid !== want.next_valid) begin
                        n_err++;
                        $error("next_valid: expected %0d, got %0d",
                               want.next_valid, out_data.next_valid);
                    end
                    if (out_data.next_id !== want.next_id) begin
                        n_err++;
                        $error("next_id: expected %0d, got %0d", want.next_id, out_data.next_id);
                    end
                end
            end
            if (in_valid && in_ready) begin
                want = apply_beat(in_data);
                expected_results.push_back(want);
                n_accepted++;
                if (q_count > peak_fill) peak_fill = q_count;
                case (in_data.cmd)
                    CMD_INSERT: begin
                        if (in_data.priority_req >= NUM_LEVELS) n_ignored++;
                        else if (want.ok) n_stored++;
                        else n_refused++;
                    end
                    CMD_REMOVE: begin
                        if (want.ok) n_found++;
                        else n_missed++;
                    end
                    default: n_peeks++;
                endcase
            end
            if (cfg_valid && cfg_ready) begin
                q_limit = cfg_data;
                n_limits++;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        int quiet;
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet == STALL_MAX) begin
                $display("Run stalled with %0d results outstanding.", expected_results.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic add_beat(input logic [CMD_W-1:0] cmd, input int id, input int prio);
        t_in b;
        b.cmd          = cmd;
        b.task_id      = id[ID_W-1:0];
        b.priority_req = prio[PRIO_W-1:0];
        pending_beats.push_back(b);
        n_pushed++;
    endtask

    // Most ids come from a small pool so that removals hit and duplicates occur.
    task automatic add_random(input int count, input int ins_pct, input int rem_pct);
        int r;
        int id;
        int prio;
        for (int i = 0; i < POOL_N; i++) id_pool[i] = $urandom_range(0, 1023);
        for (int n = 0; n < count; n++) begin
            r    = $urandom_range(0, 99);
            id   = ($urandom_range(0, 99) < 75) ? id_pool[$urandom_range(0, POOL_N - 1)]
                                                 : $urandom_range(0, 1023);
            prio = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3) : $urandom_range(4, 7);
            if (r < ins_pct) add_beat(CMD_INSERT, id, prio);
            else if (r < ins_pct + rem_pct) add_beat(CMD_REMOVE, id, prio);
            else if (r % 2 == 0) add_beat(CMD_PEEK, id, prio);
            else add_beat(CMD_UNUSED, id, prio);
        end
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (n_accepted != n_pushed || expected_results.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [CFG_W-1:0] value);
        wait_drained();
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge i_clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        rst_n <= 1'b1;

        add_beat(CMD_PEEK, 0, 0);
        add_beat(CMD_UNUSED, 1023, 7);
        add_beat(CMD_REMOVE, 0, 0);
        add_beat(CMD_INSERT, 1023, 3);
        add_beat(CMD_INSERT, 0, 0);
        add_beat(CMD_INSERT, 5, 1);
        add_beat(CMD_INSERT, 5, 1);
        add_beat(CMD_INSERT, 7, 2);
        add_beat(CMD_INSERT, 682, 7);
        add_beat(CMD_INSERT, 341, 4);
        add_beat(CMD_PEEK, 0, 0);
        add_beat(CMD_REMOVE, 5, 0);
        add_beat(CMD_REMOVE, 999, 0);
        add_beat(CMD_REMOVE, 0, 0);
        add_beat(CMD_INSERT, 341, 0);
        add_beat(CMD_UNUSED, 682, 0);
        add_beat(CMD_REMOVE, 341, 5);
        add_beat(CMD_REMOVE, 5, 0);
        add_beat(CMD_REMOVE, 7, 0);
        add_beat(CMD_REMOVE, 1023, 0);
        add_beat(CMD_PEEK, 1023, 0);

        write_limit(5'd0);
        add_beat(CMD_INSERT, 1, 0);
        add_beat(CMD_INSERT, 2, 5);
        add_beat(CMD_INSERT, 3, 6);
        add_beat(CMD_REMOVE, 1, 0);
        add_beat(CMD_PEEK, 0, 0);

        // A limit above the capacity; the receiver then holds off so the block backs up.
        write_limit(5'd31);
        add_random(200, 60, 25);
        @(posedge i_clk);
        hold_seq <= hold_seq + 1;

        write_limit(5'd16);
        add_random(60, 90, 5);

        write_limit(5'd3);
        add_random(150, 40, 40);

        write_limit(5'd5);
        idle_pct <= 0;
        add_random(150, 50, 35);

        wait_drained();
        idle_pct <= 32;
        write_limit(MAX_ENTRIES_RST);
        add_random(150, 50, 35);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            n_err++;
            $error("%0d expected results never arrived", expected_results.size());
        end

        $display("Checked %0d results over %0d limits: %0d stored, %0d refused, %0d bad levels.",
                 n_results, n_limits, n_stored, n_refused, n_ignored);
        $display("Removals found %0d and missed %0d, %0d peeks, queue held at most %0d ids.",
                 n_found, n_missed, n_peeks, peak_fill);
        if (n_err == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
